// ===== src/thz_pkg.sv =====
// Package: zone codes, configuration types and reset values for the zone classifier.
package thz_pkg;

  localparam int unsigned TempW = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    ZN_NONE = 3'd0,
    ZN_UT   = 3'd1,
    ZN_LT   = 3'd2,
    ZN_STL  = 3'd3,
    ZN_RT   = 3'd4,
    ZN_STH  = 3'd5,
    ZN_HT   = 3'd6,
    ZN_OT   = 3'd7
  } thz_zone_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_UNDER_TEMP = 3'd0,
    REG_LOW_TEMP   = 3'd1,
    REG_ROOM_LOW   = 3'd2,
    REG_ROOM_HIGH  = 3'd3,
    REG_HIGH_TEMP  = 3'd4,
    REG_OVER_TEMP  = 3'd5,
    REG_HYSTERESIS = 3'd6,
    REG_UNUSED     = 3'd7
  } thz_reg_e;

  typedef struct packed {
    logic [TempW-1:0] under_temp_limit;
    logic [TempW-1:0] low_temp_limit;
    logic [TempW-1:0] room_low_limit;
    logic [TempW-1:0] room_high_limit;
    logic [TempW-1:0] high_temp_limit;
    logic [TempW-1:0] over_temp_limit;
    logic [TempW-1:0] hysteresis;
  } thz_cfg_t;

  localparam thz_cfg_t CfgReset = '{
    under_temp_limit: 16'd2731,
    low_temp_limit:   16'd2831,
    room_low_limit:   16'd2881,
    room_high_limit:  16'd3181,
    high_temp_limit:  16'd3281,
    over_temp_limit:  16'd3331,
    hysteresis:       16'd50
  };

endpackage

// ===== src/thz_in_if.sv =====
// Interface: input channel carrying one temperature sample per item.
interface thz_in_if
  import thz_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [TempW-1:0] temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

// ===== src/thz_out_if.sv =====
// Interface: result channel carrying zone and suspend flag per item.
interface thz_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] zone;
  logic       suspend;

  modport source (output valid, output zone, output suspend, input ready);
  modport sink   (input valid, input zone, input suspend, output ready);
endinterface

// ===== src/thz_cfg_regs.sv =====
// Configuration register bank: thresholds and hysteresis with write port.
module thz_cfg_regs
  import thz_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TempW-1:0]   cfg_wdata_i,
  output thz_cfg_t           cfg_o
);

  thz_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (thz_reg_e'(cfg_idx_i))
        REG_UNDER_TEMP: cfg_d.under_temp_limit = cfg_wdata_i;
        REG_LOW_TEMP:   cfg_d.low_temp_limit   = cfg_wdata_i;
        REG_ROOM_LOW:   cfg_d.room_low_limit   = cfg_wdata_i;
        REG_ROOM_HIGH:  cfg_d.room_high_limit  = cfg_wdata_i;
        REG_HIGH_TEMP:  cfg_d.high_temp_limit  = cfg_wdata_i;
        REG_OVER_TEMP:  cfg_d.over_temp_limit  = cfg_wdata_i;
        REG_HYSTERESIS: cfg_d.hysteresis       = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/thz_classify.sv =====
// Zone classifier: next zone from sample, current zone and thresholds.
module thz_classify
  import thz_pkg::*;
(
  input  logic [TempW-1:0] temp_i,
  input  thz_zone_e        zone_i,
  input  thz_cfg_t         cfg_i,
  output thz_zone_e        zone_o
);

  localparam int unsigned SumW = TempW + 1;

  logic [SumW-1:0] t_ext;
  logic [SumW-1:0] t_plus_h;
  logic [SumW-1:0] ut_plus_h, lt_plus_h, rl_plus_h;
  logic            gt_ut_h, gt_lt_h, gt_rl_h;
  logic            lt_rh_h, lt_ht_h, lt_ot_h;
  logic            colder, hotter;
  thz_zone_e       try_low, try_std_low, try_high, try_std_high;

  // t < b - h is evaluated as t + h < b, so nothing goes negative
  assign t_ext     = {1'b0, temp_i};
  assign t_plus_h  = t_ext + {1'b0, cfg_i.hysteresis};
  assign ut_plus_h = {1'b0, cfg_i.under_temp_limit} + {1'b0, cfg_i.hysteresis};
  assign lt_plus_h = {1'b0, cfg_i.low_temp_limit} + {1'b0, cfg_i.hysteresis};
  assign rl_plus_h = {1'b0, cfg_i.room_low_limit} + {1'b0, cfg_i.hysteresis};

  assign gt_ut_h = t_ext > ut_plus_h;
  assign gt_lt_h = t_ext > lt_plus_h;
  assign gt_rl_h = t_ext > rl_plus_h;
  assign lt_rh_h = t_plus_h < {1'b0, cfg_i.room_high_limit};
  assign lt_ht_h = t_plus_h < {1'b0, cfg_i.high_temp_limit};
  assign lt_ot_h = t_plus_h < {1'b0, cfg_i.over_temp_limit};

  assign colder = (zone_i == ZN_UT) || (zone_i == ZN_LT) || (zone_i == ZN_STL);
  assign hotter = (zone_i == ZN_STH) || (zone_i == ZN_HT) || (zone_i == ZN_OT);

  assign try_low      = gt_ut_h ? ZN_LT  : zone_i;
  assign try_std_low  = gt_lt_h ? ZN_STL : try_low;
  assign try_high     = lt_ot_h ? ZN_HT  : zone_i;
  assign try_std_high = lt_ht_h ? ZN_STH : try_high;

  always_comb begin
    if (temp_i < cfg_i.under_temp_limit) begin
      zone_o = ZN_UT;
    end else if (temp_i < cfg_i.low_temp_limit) begin
      zone_o = (zone_i == ZN_UT) ? try_low : ZN_LT;
    end else if (temp_i < cfg_i.room_low_limit) begin
      zone_o = ((zone_i == ZN_UT) || (zone_i == ZN_LT)) ? try_std_low : ZN_STL;
    end else if (temp_i <= cfg_i.room_high_limit) begin
      if (colder) begin
        zone_o = gt_rl_h ? ZN_RT : try_std_low;
      end else if (hotter) begin
        zone_o = lt_rh_h ? ZN_RT : try_std_high;
      end else begin
        zone_o = ZN_RT;
      end
    end else if (temp_i <= cfg_i.high_temp_limit) begin
      zone_o = ((zone_i == ZN_HT) || (zone_i == ZN_OT)) ? try_std_high : ZN_STH;
    end else if (temp_i <= cfg_i.over_temp_limit) begin
      zone_o = (zone_i == ZN_OT) ? try_high : ZN_HT;
    end else begin
      zone_o = ZN_OT;
    end
  end

endmodule

// ===== src/temperature_zone_hysteresis.sv =====
// A sample waits in the sample register until the result register frees or drains.
// Throughput: one item per cycle while the result side is ready; the sample register
// and the result register form a two-stage pipeline, and the zone register doubles as
// the result payload. Reset: thresholds and hysteresis return to their defaults,
// zone to none, both pipeline stages empty.
module temperature_zone_hysteresis
  import thz_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TempW-1:0]   cfg_wdata_i,
  thz_in_if.sink             in_i,
  thz_out_if.source          out_o
);

  thz_cfg_t         cfg;
  logic             in_valid_q;
  logic [TempW-1:0] temp_q;
  logic             out_valid_q;
  thz_zone_e        zone_q, zone_d;
  logic             advance;

  thz_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  thz_classify u_classify (
    .temp_i (temp_q),
    .zone_i (zone_q),
    .cfg_i  (cfg),
    .zone_o (zone_d)
  );

  // move the held sample into the result register when it is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      temp_q <= in_i.temperature;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      zone_q      <= ZN_NONE;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        zone_q      <= zone_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.zone    = zone_q;
  assign out_o.suspend = (zone_q == ZN_UT) || (zone_q == ZN_OT);

  a_advance_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_o.valid)
    else $error("result missing after pipeline advance");

  a_stall_holds_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |=> (in_valid_q && $stable(zone_q)))
    else $error("zone or held sample changed during stall");

  a_result_has_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (zone_q != ZN_NONE))
    else $error("result delivered with no zone");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready)
    else $error("empty sample stage refuses an item");

endmodule

// ===== verif/tb_temperature_zone_hysteresis.sv =====
// Testbench: temperature zone classifier checked against a local zone predictor.
`timescale 1ns / 1ps

module tb_temperature_zone_hysteresis
  import thz_pkg::*;
();

  typedef struct packed {
    thz_zone_e zone;
    logic      suspend;
  } zone_result_t;

  typedef struct {
    logic [TempW-1:0] temp;
    bit               typed;
    thz_zone_e        zone;
  } sample_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [TempW-1:0]   cfg_wdata_i;

  thz_in_if  in_if ();
  thz_out_if out_if ();

  temperature_zone_hysteresis i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  thz_cfg_t         model_cfg = CfgReset;
  thz_zone_e        model_zone = ZN_NONE;
  logic [TempW-1:0] last_temp = '0;
  zone_result_t     pending_results[$];
  int               mismatches = 0;
  bit               quiet = 1'b0;

  // Walk the zones up across every hysteresis band and back down across the hot-side bands at reset thresholds.
  sample_row_t sweep_rows [19] = '{
    '{16'd3000,  1'b1, ZN_RT},   // no zone yet: room taken directly
    '{16'd0,     1'b1, ZN_UT},
    '{16'd2740,  1'b0, ZN_NONE},
    '{16'd2782,  1'b0, ZN_NONE},
    '{16'd2790,  1'b0, ZN_NONE},
    '{16'd2860,  1'b0, ZN_NONE},
    '{16'd2882,  1'b0, ZN_NONE},
    '{16'd2932,  1'b0, ZN_NONE},
    '{16'd3200,  1'b0, ZN_NONE},
    '{16'd3282,  1'b0, ZN_NONE},
    '{16'd3332,  1'b0, ZN_NONE},
    '{16'd3300,  1'b0, ZN_NONE},
    '{16'd3280,  1'b0, ZN_NONE},
    '{16'd3230,  1'b0, ZN_NONE},
    '{16'd3150,  1'b0, ZN_NONE},
    '{16'd3130,  1'b0, ZN_NONE},
    '{16'd65535, 1'b1, ZN_OT},
    '{16'd2900,  1'b0, ZN_NONE},
    '{16'd0,     1'b1, ZN_UT}
  };

  function automatic thz_zone_e classify_zone(thz_cfg_t c, thz_zone_e z,
                                              logic [TempW-1:0] temp);
    int        t, h, t1, t2, t5, t6, t3, t4;
    bit        colder, hotter;
    thz_zone_e low_up, stl_up, high_dn, sth_dn, nz;
    t  = temp;
    h  = c.hysteresis;
    t1 = c.under_temp_limit;
    t2 = c.low_temp_limit;
    t5 = c.room_low_limit;
    t6 = c.room_high_limit;
    t3 = c.high_temp_limit;
    t4 = c.over_temp_limit;
    colder = z inside {ZN_UT, ZN_LT, ZN_STL};
    hotter = z inside {ZN_STH, ZN_HT, ZN_OT};
    // fall-through chains: nearest qualifying zone, else hold the current one
    low_up  = (t > t1 + h) ? ZN_LT : z;
    stl_up  = (t > t2 + h) ? ZN_STL : low_up;
    high_dn = (t < t4 - h) ? ZN_HT : z;
    sth_dn  = (t < t3 - h) ? ZN_STH : high_dn;
    if (t < t1) nz = ZN_UT;
    else if (t < t2) nz = (z == ZN_UT) ? low_up : ZN_LT;
    else if (t < t5) nz = (z inside {ZN_UT, ZN_LT}) ? stl_up : ZN_STL;
    else if (t <= t6) begin
      if (colder) nz = (t > t5 + h) ? ZN_RT : stl_up;
      else if (hotter) nz = (t < t6 - h) ? ZN_RT : sth_dn;
      else nz = ZN_RT;
    end
    else if (t <= t3) nz = (z inside {ZN_HT, ZN_OT}) ? sth_dn : ZN_STH;
    else if (t <= t4) nz = (z == ZN_OT) ? high_dn : ZN_HT;
    else nz = ZN_OT;
    return nz;
  endfunction

  // Samples around thresholds and band edges, slow drifts, and occasional random or extreme values.
  function automatic logic [TempW-1:0] pick_temp();
    int v, h, s, bound, sel;
    h   = model_cfg.hysteresis;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      v = $urandom_range(0, 65535);
    end else if (sel == 1) begin
      v = $urandom_range(0, 1) ? 65535 : 0;
    end else if (sel < 8) begin
      case ($urandom_range(0, 5))
        0: bound = model_cfg.under_temp_limit;
        1: bound = model_cfg.low_temp_limit;
        2: bound = model_cfg.room_low_limit;
        3: bound = model_cfg.room_high_limit;
        4: bound = model_cfg.high_temp_limit;
        default: bound = model_cfg.over_temp_limit;
      endcase
      case ($urandom_range(0, 2))
        0: v = bound;
        1: v = bound + h;
        default: v = bound - h;
      endcase
      v = v + int'($urandom_range(0, 4)) - 2;
    end else begin
      s = (h / 2 + 8 > 500) ? 500 : h / 2 + 8;
      v = int'(last_temp) + int'($urandom_range(0, 2 * s)) - s;
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[TempW-1:0];
  endfunction

  task automatic send_sample(input logic [TempW-1:0] temp, input bit typed,
                             input thz_zone_e typed_zone);
    zone_result_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.temperature <= temp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r.zone    = typed ? typed_zone : classify_zone(model_cfg, model_zone, temp);
    r.suspend = r.zone inside {ZN_UT, ZN_OT};
    model_zone = r.zone;
    last_temp  = temp;
    pending_results.push_back(r);
  endtask

  // Hold the sender until every expected item has come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input thz_reg_e idx, input logic [TempW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_UNDER_TEMP: model_cfg.under_temp_limit = val;
      REG_LOW_TEMP:   model_cfg.low_temp_limit   = val;
      REG_ROOM_LOW:   model_cfg.room_low_limit   = val;
      REG_ROOM_HIGH:  model_cfg.room_high_limit  = val;
      REG_HIGH_TEMP:  model_cfg.high_temp_limit  = val;
      REG_OVER_TEMP:  model_cfg.over_temp_limit  = val;
      REG_HYSTERESIS: model_cfg.hysteresis       = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input thz_cfg_t c);
    write_reg(REG_UNDER_TEMP, c.under_temp_limit);
    write_reg(REG_LOW_TEMP,   c.low_temp_limit);
    write_reg(REG_ROOM_LOW,   c.room_low_limit);
    write_reg(REG_ROOM_HIGH,  c.room_high_limit);
    write_reg(REG_HIGH_TEMP,  c.high_temp_limit);
    write_reg(REG_OVER_TEMP,  c.over_temp_limit);
    write_reg(REG_HYSTERESIS, c.hysteresis);
    // the unused index must leave every limit alone
    write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
  endtask

  function automatic thz_cfg_t ascending_cfg(int max_hyst);
    thz_cfg_t c;
    int       v;
    v = $urandom_range(0, 20000);
    c.under_temp_limit = v[TempW-1:0];
    v += $urandom_range(0, 3000);
    c.low_temp_limit = v[TempW-1:0];
    v += $urandom_range(0, 3000);
    c.room_low_limit = v[TempW-1:0];
    v += $urandom_range(0, 3000);
    c.room_high_limit = v[TempW-1:0];
    v += $urandom_range(0, 3000);
    c.high_temp_limit = v[TempW-1:0];
    v += $urandom_range(0, 3000);
    c.over_temp_limit = v[TempW-1:0];
    c.hysteresis = 16'($urandom_range(0, max_hyst));
    return c;
  endfunction

  initial begin
    thz_cfg_t c;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= REG_UNDER_TEMP;
    cfg_wdata_i       <= '0;
    in_if.valid       <= 1'b0;
    in_if.temperature <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (sweep_rows[i])
      send_sample(sweep_rows[i].temp, sweep_rows[i].typed, sweep_rows[i].zone);

    for (int ph = 1; ph <= 6; ph++) begin
      drain();
      case (ph)
        1: c = '0;
        2: c = '1;
        3: c = ascending_cfg(200);
        // band wider than the limits: lower bound minus band goes negative
        4: begin
          c = ascending_cfg(0);
          c.hysteresis = 16'($urandom_range(30000, 65535));
        end
        // limits in any order
        5: c = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 3000))};
        default: c = ascending_cfg(400);
      endcase
      apply_cfg(c);
      quiet = (ph == 6);
      for (int n = 0; n < 72; n++) begin
        send_sample(pick_temp(), 1'b0, ZN_NONE);
        if (!quiet && $urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("** temperature_zone_hysteresis: PASSED **");
    end else begin
      $display("** temperature_zone_hysteresis: FAILED **");
    end
    $finish;
  end

  // Result side backpressure in random bursts.
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    zone_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item: zone %0d suspend %0d", $time,
                 out_if.zone, out_if.suspend);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.zone !== want.zone) begin
          $display("%0t: zone mismatch: expected %0d actual %0d", $time,
                   want.zone, out_if.zone);
          mismatches++;
        end
        if (out_if.suspend !== want.suspend) begin
          $display("%0t: suspend mismatch: expected %0d actual %0d", $time,
                   want.suspend, out_if.suspend);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout at %0t", $time);
    $display("** temperature_zone_hysteresis: FAILED **");
    $finish;
  end

endmodule
